FILE: rtl/core/rwa_pkg.sv
// Shared widths, controller state encoding and control/status bundles.
`default_nettype none

package rwa_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned HALF_W    = TIME_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(TIME_W);
  localparam int unsigned IN_DATA_W = VALUE_W + 2 * TIME_W;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(TIME_W - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL_LO = 6'b000010,
    S_MUL_HI = 6'b000100,
    S_ADD_HI = 6'b001000,
    S_DIV    = 6'b010000,
    S_LOAD   = 6'b100000
  } rwa_state_t;

  typedef struct packed {
    logic load_in;
    logic mul_lo;
    logic mul_hi;
    logic add_hi;
    logic div_start;
    logic div_step;
    logic out_load;
  } rwa_cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic out_busy;
  } rwa_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/rwa_ctrl.sv
// Sequencing state machine for accumulation and the bit-serial divide.
`default_nettype none

module rwa_ctrl
  import rwa_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  rwa_status_t status,
  output rwa_cmd_t    cmd
);

  rwa_state_t state_r;
  rwa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ADD_HI;
      end
      S_ADD_HI: begin
        cmd.add_hi = 1'b1;
        state_nxt  = status.last ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_LOAD;
      end
      S_LOAD: begin
        if (!status.div_last) begin
          cmd.div_step = 1'b1;
        end else if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/rwa_dp.sv
// Accumulators, shared 32x32 multiplier, restoring divider and output register.
`default_nettype none

module rwa_dp
  import rwa_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [IN_DATA_W-1:0] in_data,
  input  wire                  in_last,
  input  rwa_cmd_t             cmd,
  output rwa_status_t          status,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [TIME_W-1:0]    out_data
);

  logic [VALUE_W-1:0]   value_r;
  logic [TIME_W-1:0]    delta_r;
  logic                 last_r;
  logic [TIME_W-1:0]    mul_r;
  logic [TIME_W-1:0]    wsum_r;
  logic [TIME_W-1:0]    tsum_r;
  logic [TIME_W-1:0]    quo_r;
  logic [TIME_W-1:0]    rem_r;
  logic [TIME_W-1:0]    dvsr_r;
  logic                 zero_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 div_done_r;
  logic                 out_valid_r;
  logic [TIME_W-1:0]    out_data_r;

  logic [VALUE_W-1:0]   in_value;
  logic [TIME_W-1:0]    in_prev;
  logic [TIME_W-1:0]    in_cur;
  logic [HALF_W-1:0]    mul_b;
  logic [TIME_W-1:0]    mul_prod;
  logic [TIME_W:0]      shifted;
  logic [TIME_W:0]      diff;

  assign in_value = in_data[VALUE_W-1:0];
  assign in_prev  = in_data[VALUE_W +: TIME_W];
  assign in_cur   = in_data[VALUE_W + TIME_W +: TIME_W];

  assign mul_b    = cmd.mul_hi ? delta_r[TIME_W-1:HALF_W] : delta_r[HALF_W-1:0];
  assign mul_prod = TIME_W'(value_r) * TIME_W'(mul_b);

  assign shifted  = {rem_r, quo_r[TIME_W-1]};
  assign diff     = shifted - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      value_r <= in_value;
      delta_r <= in_cur - in_prev;
      last_r  <= in_last;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      mul_r <= mul_prod;
    end
    if (cmd.div_start) begin
      quo_r  <= wsum_r;
      dvsr_r <= tsum_r;
      rem_r  <= '0;
      zero_r <= (tsum_r == '0);
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      if (!diff[TIME_W]) begin
        rem_r <= diff[TIME_W-1:0];
      end else begin
        rem_r <= shifted[TIME_W-1:0];
      end
      quo_r <= {quo_r[TIME_W-2:0], ~diff[TIME_W]};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= zero_r ? '0 : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r      <= '0;
      tsum_r      <= '0;
      div_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        wsum_r <= '0;
        tsum_r <= '0;
      end else if (cmd.mul_hi) begin
        wsum_r <= wsum_r + mul_r;
      end else if (cmd.add_hi) begin
        wsum_r <= wsum_r + {mul_r[HALF_W-1:0], HALF_W'(0)};
        tsum_r <= tsum_r + delta_r;
      end
      if (cmd.div_start || cmd.out_load) begin
        div_done_r <= 1'b0;
      end else if (cmd.div_step && cnt_r == DIV_LAST_STEP) begin
        div_done_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.last     = last_r;
  assign status.div_last = div_done_r;
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/residency_weighted_average.sv
// Top level of the residency-weighted average: controller plus datapath.
//
//   Channel | Direction | Payload
//   in_     | input     | tdata: state_value, prev_time, cur_time; tlast: last_entry
//   out_    | output    | tdata: average_value
//
// An item is accepted in the idle state and accumulated in order: accept,
// low and high partial products through one shared 32x32 multiplier, final add.
// An item with tlast then loads the divider, runs the one-bit-a-step restoring
// divider over all 64 quotient bits and loads the output register once it is free.
// Reset clears both sums, the controller and the output valid flag.
// A waiting result holds off the input only once the next result is ready.
`default_nettype none

module residency_weighted_average
  import rwa_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [IN_DATA_W-1:0] in_tdata,   // state_value, prev_time, cur_time
  input  wire                  in_tlast,   // last_entry
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [TIME_W-1:0]    out_tdata   // average_value
);

  rwa_cmd_t    cmd;
  rwa_status_t status;

  rwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rwa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire
